@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion helper macros shared by the clipper RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define ASSERT_IMPL(lbl, clk, rst_n, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("assertion failed");

// The condition must hold in the cycle after the trigger.
`define ASSERT_NEXT(lbl, clk, rst_n, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("assertion failed");

`endif

@@ sv/lwc_pkg.sv @@
// ----------------------------------------------------------------------------
// lwc_pkg
// Shared constants and types of the line window clipper.
// ----------------------------------------------------------------------------
package lwc_pkg;

    // Default coordinate and parameter fraction widths.
    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 16;

    // One divider lane for each window edge.
    localparam int NUM_LANES = 4;

    // Configuration register indexes.
    localparam logic [1:0] REG_LEFT   = 2'd0;
    localparam logic [1:0] REG_RIGHT  = 2'd1;
    localparam logic [1:0] REG_BOTTOM = 2'd2;
    localparam logic [1:0] REG_TOP    = 2'd3;

    // Lane order follows the edge test order.
    localparam int LANE_LEFT   = 0;
    localparam int LANE_RIGHT  = 1;
    localparam int LANE_BOTTOM = 2;
    localparam int LANE_TOP    = 3;

    // Sign and zero flags of one edge test, carried beside the quotient.
    typedef struct packed {
        logic p_zero;
        logic p_neg;
        logic q_neg;
    } t_lane_flags;

endpackage

@@ sv/lwc_div_cell.sv @@
// ----------------------------------------------------------------------------
// lwc_div_cell
// One restoring division step for every edge lane, plus a register
// stage for the segment data that rides along with the quotients.
// ----------------------------------------------------------------------------
module lwc_div_cell
    import lwc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    localparam int NQ        = COORD_BITS + FRAC_BITS,
    localparam int SW        = 4 * COORD_BITS + 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  logic                  i_valid,
    input  logic [COORD_BITS-1:0] i_rem  [NUM_LANES],
    input  logic [NQ-1:0]         i_num  [NUM_LANES],
    input  logic [NQ-1:0]         i_quo  [NUM_LANES],
    input  logic [COORD_BITS-1:0] i_den  [NUM_LANES],
    input  t_lane_flags           i_flg  [NUM_LANES],
    input  logic [SW-1:0]         i_side,
    output logic                  o_valid,
    output logic [COORD_BITS-1:0] o_rem  [NUM_LANES],
    output logic [NQ-1:0]         o_num  [NUM_LANES],
    output logic [NQ-1:0]         o_quo  [NUM_LANES],
    output logic [COORD_BITS-1:0] o_den  [NUM_LANES],
    output t_lane_flags           o_flg  [NUM_LANES],
    output logic [SW-1:0]         o_side
);

    logic [COORD_BITS-1:0] n_rem [NUM_LANES];
    logic [NUM_LANES-1:0]  n_bit;

    // Shift in the next dividend bit and subtract the divisor where it fits.
    always_comb begin
        logic [COORD_BITS:0] t;
        for (int l = 0; l < NUM_LANES; l++) begin
            t        = {i_rem[l], i_num[l][NQ-1]};
            n_bit[l] = (t >= {1'b0, i_den[l]});
            if (n_bit[l]) begin
                n_rem[l] = COORD_BITS'(t - {1'b0, i_den[l]});
            end else begin
                n_rem[l] = t[COORD_BITS-1:0];
            end
        end
    end

    // Stage valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_adv) begin
            o_valid <= i_valid;
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int l = 0; l < NUM_LANES; l++) begin
                o_rem[l] <= n_rem[l];
                o_num[l] <= {i_num[l][NQ-2:0], 1'b0};
                o_quo[l] <= {i_quo[l][NQ-2:0], n_bit[l]};
                o_den[l] <= i_den[l];
                o_flg[l] <= i_flg[l];
            end
            o_side <= i_side;
        end
    end

endmodule

@@ sv/line_window_clipper.sv @@
// ----------------------------------------------------------------------------
// line_window_clipper
// Liang-Barsky clipping of a line segment against a configured window.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall carry one segment per beat (both endpoints).
// Output channel: o_valid / i_stall carry one result per beat: a visible flag
// and the clipped endpoints, all zero when the segment is rejected.
// The window is set through i_cfg_we / i_cfg_idx / i_cfg_wdata; the user
// must write it only while idle, as the block does not enforce this.
// Throughput is one segment per cycle while o_stall is low. Each accepted
// beat passes through a chain of division cells, one quotient bit per cell,
// that give the ratio of each window edge, then the edge test stage, the multiply
// stage and the output register. When the receiver stalls while a finished
// result waits in the output register, the whole pipeline holds and o_stall rises.
// Reset empties the pipeline and loads the window with left and bottom 0 and
// right and top at the largest positive coordinate.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module line_window_clipper
    import lwc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_idx,
    input  logic signed [COORD_BITS-1:0] i_cfg_wdata,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_visible,
    output logic signed [COORD_BITS-1:0] o_clip_start_x,
    output logic signed [COORD_BITS-1:0] o_clip_start_y,
    output logic signed [COORD_BITS-1:0] o_clip_end_x,
    output logic signed [COORD_BITS-1:0] o_clip_end_y
);

    localparam int C  = COORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int NQ = C + F;
    localparam int SW = 4 * C + 2;
    localparam int W  = NQ + 2;
    localparam int PW = F + C + 3;

    // Window registers.
    logic signed [C-1:0] r_left, r_right, r_bottom, r_top;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_right  <= {1'b0, {(C-1){1'b1}}};
            r_bottom <= '0;
            r_top    <= {1'b0, {(C-1){1'b1}}};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_LEFT:   r_left   <= i_cfg_wdata;
                REG_RIGHT:  r_right  <= i_cfg_wdata;
                REG_BOTTOM: r_bottom <= i_cfg_wdata;
                REG_TOP:    r_top    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // The whole pipeline moves unless a result waits on a stalled receiver.
    logic w_adv;
    assign w_adv   = !o_valid || !i_stall;
    assign o_stall = !w_adv;

    // Front end: edge terms p and q, their magnitudes and signs.
    logic signed [C:0]   w_dx, w_dy;
    logic signed [C:0]   w_p [NUM_LANES];
    logic signed [C:0]   w_q [NUM_LANES];
    logic [C-1:0]        s_rem [0:NQ][NUM_LANES];
    logic [NQ-1:0]       s_num [0:NQ][NUM_LANES];
    logic [NQ-1:0]       s_quo [0:NQ][NUM_LANES];
    logic [C-1:0]        s_den [0:NQ][NUM_LANES];
    t_lane_flags         s_flg [0:NQ][NUM_LANES];
    logic [SW-1:0]       s_side [0:NQ];
    logic                s_valid [0:NQ];

    assign w_dx = $signed({i_end_x[C-1], i_end_x}) - $signed({i_start_x[C-1], i_start_x});
    assign w_dy = $signed({i_end_y[C-1], i_end_y}) - $signed({i_start_y[C-1], i_start_y});

    always_comb begin
        logic [C:0] ap, aq;
        w_p[LANE_LEFT]   = -w_dx;
        w_q[LANE_LEFT]   = $signed({i_start_x[C-1], i_start_x}) - $signed({r_left[C-1], r_left});
        w_p[LANE_RIGHT]  = w_dx;
        w_q[LANE_RIGHT]  = $signed({r_right[C-1], r_right}) - $signed({i_start_x[C-1], i_start_x});
        w_p[LANE_BOTTOM] = -w_dy;
        w_q[LANE_BOTTOM] = $signed({i_start_y[C-1], i_start_y})
                         - $signed({r_bottom[C-1], r_bottom});
        w_p[LANE_TOP]    = w_dy;
        w_q[LANE_TOP]    = $signed({r_top[C-1], r_top}) - $signed({i_start_y[C-1], i_start_y});
        for (int l = 0; l < NUM_LANES; l++) begin
            ap = w_p[l][C] ? -w_p[l] : w_p[l];
            aq = w_q[l][C] ? -w_q[l] : w_q[l];
            s_rem[0][l]        = '0;
            s_num[0][l]        = {aq[C-1:0], {F{1'b0}}};
            s_quo[0][l]        = '0;
            s_den[0][l]        = ap[C-1:0];
            s_flg[0][l].p_zero = (w_p[l] == '0);
            s_flg[0][l].p_neg  = w_p[l][C];
            s_flg[0][l].q_neg  = w_q[l][C];
        end
    end

    assign s_side[0]  = {i_start_x, i_start_y, w_dx, w_dy};
    assign s_valid[0] = i_valid;

    // Chain of division cells, one quotient bit each.
    for (genvar k = 0; k < NQ; k++) begin : g_div
        lwc_div_cell #(
            .COORD_BITS (COORD_BITS),
            .FRAC_BITS  (FRAC_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_valid (s_valid[k]),
            .i_rem   (s_rem[k]),
            .i_num   (s_num[k]),
            .i_quo   (s_quo[k]),
            .i_den   (s_den[k]),
            .i_flg   (s_flg[k]),
            .i_side  (s_side[k]),
            .o_valid (s_valid[k+1]),
            .o_rem   (s_rem[k+1]),
            .o_num   (s_num[k+1]),
            .o_quo   (s_quo[k+1]),
            .o_den   (s_den[k+1]),
            .o_flg   (s_flg[k+1]),
            .o_side  (s_side[k+1])
        );
    end

    // Edge tests in order: left, right, bottom, top.
    logic              n_eok;
    logic signed [W-1:0] n_u1, n_u2;

    always_comb begin
        logic signed [W-1:0] r;
        logic signed [W-1:0] mag;
        n_eok = 1'b1;
        n_u1  = '0;
        n_u2  = W'(1) << F;
        for (int l = 0; l < NUM_LANES; l++) begin
            mag = $signed({2'b00, s_quo[NQ][l]});
            r   = (s_flg[NQ][l].p_neg ^ s_flg[NQ][l].q_neg) ? -mag : mag;
            if (s_flg[NQ][l].p_zero) begin
                if (s_flg[NQ][l].q_neg) n_eok = 1'b0;
            end else if (s_flg[NQ][l].p_neg) begin
                if (r > n_u2) n_eok = 1'b0;
                else if (r > n_u1) n_u1 = r;
            end else begin
                if (r < n_u1) n_eok = 1'b0;
                else if (r < n_u2) n_u2 = r;
            end
        end
    end

    logic          r_ev, r_eok;
    logic [F:0]    r_eu1, r_eu2;
    logic [SW-1:0] r_eside;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev <= 1'b0;
        end else if (w_adv) begin
            r_ev <= s_valid[NQ];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_eok   <= n_eok;
            r_eu1   <= n_u1[F:0];
            r_eu2   <= n_u2[F:0];
            r_eside <= s_side[NQ];
        end
    end

    // Multiply stage: parameter times delta for each output coordinate.
    logic signed [C-1:0] w_x1, w_y1;
    logic signed [C:0]   w_edx, w_edy;
    assign {w_x1, w_y1, w_edx, w_edy} = r_eside;

    logic                 r_mv, r_mok;
    logic signed [PW-1:0] r_m1x, r_m1y, r_m2x, r_m2y;
    logic signed [C-1:0]  r_mx1, r_my1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
        end else if (w_adv) begin
            r_mv <= r_ev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_mok <= r_eok;
            r_m1x <= PW'($signed({1'b0, r_eu1}) * w_edx);
            r_m1y <= PW'($signed({1'b0, r_eu1}) * w_edy);
            r_m2x <= PW'($signed({1'b0, r_eu2}) * w_edx);
            r_m2y <= PW'($signed({1'b0, r_eu2}) * w_edy);
            r_mx1 <= w_x1;
            r_my1 <= w_y1;
        end
    end

    // Place a point: base plus product, truncated toward zero.
    function automatic logic [C-1:0] place(input logic signed [C-1:0] base,
                                           input logic signed [PW-1:0] prod);
        logic signed [PW-1:0] s;
        logic signed [PW-1:0] t;
        s = (PW'(base) <<< F) + prod;
        if (s < 0) s = s + PW'((1 << F) - 1);
        t = s >>> F;
        return t[C-1:0];
    endfunction

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_adv) begin
            o_valid <= r_mv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            o_visible      <= r_mok;
            o_clip_start_x <= r_mok ? place(r_mx1, r_m1x) : '0;
            o_clip_start_y <= r_mok ? place(r_my1, r_m1y) : '0;
            o_clip_end_x   <= r_mok ? place(r_mx1, r_m2x) : '0;
            o_clip_end_y   <= r_mok ? place(r_my1, r_m2y) : '0;
        end
    end

    // A rejected result carries all-zero coordinates.
    `ASSERT_IMPL(a_reject_zero, i_clk, i_rst_n, o_valid && !o_visible, o_clip_start_x == '0 && o_clip_start_y == '0 && o_clip_end_x == '0 && o_clip_end_y == '0)
    // An accepted segment never leaves entry beyond exit.
    `ASSERT_IMPL(a_entry_exit, i_clk, i_rst_n, r_ev && r_eok, r_eu1 <= r_eu2)
    // A new result only comes from a valid multiply stage.
    `ASSERT_IMPL(a_out_source, i_clk, i_rst_n, $rose(o_valid), $past(r_mv))

endmodule
